// ===== hdl/apq_pkg.sv =====
// Shared types and codes for the array priority queue.
// No dependencies; used by apq_cell and array_priority_queue.
package apq_pkg;

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_PEEK = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int FILL_W  = 7;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         priority_req;
  } req_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] out_value;
    logic [PRIO_W-1:0]         out_priority;
    logic [FILL_W-1:0]         fill;
  } rsp_item_t;

  // Row-wide command broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

// ===== hdl/apq_cell.sv =====
// One storage cell of the priority queue row.
// Depends on apq_pkg; instantiated by array_priority_queue.
module apq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int PB  = 8
) (
  input  logic                               clk,
  input  apq_pkg::cell_ctl_t                 ctl,
  input  logic [CW-1:0]                      count,
  input  logic signed [apq_pkg::VALUE_W-1:0] new_value,
  input  logic [PB-1:0]                      new_prio,
  input  logic                               left_keep,
  input  logic signed [apq_pkg::VALUE_W-1:0] left_value,
  input  logic [PB-1:0]                      left_prio,
  input  logic signed [apq_pkg::VALUE_W-1:0] right_value,
  input  logic [PB-1:0]                      right_prio,
  output logic                               keep,
  output logic signed [apq_pkg::VALUE_W-1:0] value,
  output logic [PB-1:0]                      prio
);
  import apq_pkg::*;

  // Held entry that outranks (or ties with, being older) the new one stays put.
  assign keep = (CW'(IDX) < count) && (prio >= new_prio);

  always_ff @(posedge clk) begin
    if (ctl.insert && !keep) begin
      if (left_keep) begin
        value <= new_value;
        prio  <= new_prio;
      end else begin
        value <= left_value;
        prio  <= left_prio;
      end
    end else if (ctl.remove) begin
      value <= right_value;
      prio  <= right_prio;
    end
  end

endmodule

// ===== hdl/array_priority_queue.sv =====
// Top level of the array priority queue: request/response handshake,
// entry count and the row of apq_cell instances. Depends on apq_pkg.
//
// Bounded priority queue of (value, priority) pairs, up to CAPACITY entries.
// A request enqueues a pair, peeks at the best entry or dequeues it; the best
// entry is the one of highest priority, the oldest among equals. One response
// item comes back for every request item. The entries live in a row of cells
// kept sorted: highest priority at cell 0, ties in arrival order. An enqueue
// is a broadcast compare in every cell followed by a one-place shift toward
// the tail from the insertion point; a dequeue shifts the whole row one place
// toward the head. Either way the row is updated at the accepting edge, so a
// request is taken in every cycle in which the response register is free or is
// being emptied, and its response appears in that register in the cycle after
// acceptance. The response register lets a new request in while the previous
// response is taken in the same cycle. Priorities are kept to their low
// PRIORITY_BITS bits. An enqueue into a full queue reports full and drops the
// pair; a peek or dequeue on an empty queue reports empty. Mode three is
// ignored and answered with status ok. The fill field is the entry count
// after the request, taken to its low seven bits.
module array_priority_queue #(
  parameter int CAPACITY      = 64,
  parameter int PRIORITY_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  apq_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output apq_pkg::rsp_item_t rsp
);
  import apq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PB = PRIORITY_BITS;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  rsp_item_t     rsp_next;
  cell_ctl_t     ctl;
  logic          accept;

  logic [PB-1:0]       new_prio;
  logic [PB+PRIO_W-1:0] req_prio_ext;
  logic [PB+PRIO_W-1:0] top_prio_ext;
  logic [CW+FILL_W-1:0] fill_ext;

  logic                      keep  [CAPACITY];
  logic signed [VALUE_W-1:0] cval  [CAPACITY];
  logic [PB-1:0]             cprio [CAPACITY];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // Fit the request priority into PRIORITY_BITS, and back out to eight bits.
  assign req_prio_ext = {{PB{1'b0}}, req.priority_req};
  assign new_prio     = req_prio_ext[PB-1:0];
  assign top_prio_ext = {{PRIO_W{1'b0}}, cprio[0]};
  assign fill_ext     = {{FILL_W{1'b0}}, count_next};

  always_comb begin
    ctl                = '0;
    count_next         = count;
    rsp_next.status    = STATUS_OK;
    rsp_next.out_value = '0;
    rsp_next.out_priority = '0;
    if (req.mode == MODE_ENQ) begin
      if (count == CW'(CAPACITY)) begin
        rsp_next.status = STATUS_FULL;
      end else begin
        ctl.insert = accept;
        count_next = count + CW'(1);
      end
    end else if (req.mode == MODE_DEQ || req.mode == MODE_PEEK) begin
      if (count == '0) begin
        rsp_next.status = STATUS_EMPTY;
      end else begin
        rsp_next.out_value    = cval[0];
        rsp_next.out_priority = top_prio_ext[PRIO_W-1:0];
        if (req.mode == MODE_DEQ) begin
          ctl.remove = accept;
          count_next = count - CW'(1);
        end
      end
    end
    rsp_next.fill = fill_ext[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Row of cells; cell 0 holds the best entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      lk;
    logic signed [VALUE_W-1:0] lv;
    logic [PB-1:0]             lp;
    logic signed [VALUE_W-1:0] rv;
    logic [PB-1:0]             rp;

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lv = '0;
      assign lp = '0;
    end else begin : g_body
      assign lk = keep[i-1];
      assign lv = cval[i-1];
      assign lp = cprio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv = '0;
      assign rp = '0;
    end else begin : g_inner
      assign rv = cval[i+1];
      assign rp = cprio[i+1];
    end

    apq_cell #(
      .IDX (i),
      .CW  (CW),
      .PB  (PB)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .new_value   (req.value),
      .new_prio    (new_prio),
      .left_keep   (lk),
      .left_value  (lv),
      .left_prio   (lp),
      .right_value (rv),
      .right_prio  (rp),
      .keep        (keep[i]),
      .value       (cval[i]),
      .prio        (cprio[i])
    );
  end

endmodule
